>>> hw/rtl/hsi_pkg.sv
// Shared types, sizes and helpers for the bucketed hash set.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package hsi_pkg;

	localparam int BUCKETS    = 256;
	localparam int WAYS       = 4;
	localparam int KEY_BITS   = 32;
	localparam int IN_KEY_BITS = 32;
	localparam int IDX_BITS   = $clog2(BUCKETS);
	localparam int WAY_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int COUNT_BITS = 11;
	localparam int COUNT_MAX  = 2047;
	localparam int KEY_EXT    = (KEY_BITS > IN_KEY_BITS) ? KEY_BITS : IN_KEY_BITS;
	localparam int IDX_EXT    = (IDX_BITS > KEY_BITS) ? IDX_BITS : KEY_BITS;

	typedef enum logic {
		OP_ADD   = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef struct packed {
		op_t                    op;
		logic [IN_KEY_BITS-1:0] key;
	} req_t;

	typedef struct packed {
		logic                  hit;
		logic                  bucket_full;
		logic [COUNT_BITS-1:0] count;
	} res_t;

	typedef struct packed {
		op_t                 op;
		logic [IDX_BITS-1:0] idx;
		logic [KEY_BITS-1:0] key;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_beat_t;

	function automatic logic [KEY_BITS-1:0] mask_key(input logic [IN_KEY_BITS-1:0] key);
		logic [KEY_EXT-1:0] ext;
		ext = KEY_EXT'(key);
		return ext[KEY_BITS-1:0];
	endfunction

	function automatic logic [IDX_BITS-1:0] bucket_of(input logic [KEY_BITS-1:0] key);
		logic [IDX_EXT-1:0] ext;
		ext = IDX_EXT'(key);
		return ext[IDX_BITS-1:0];
	endfunction

endpackage

>>> hw/rtl/hsi_front.sv
// Front end: accepts request beats, masks the key, picks the bucket and
// holds the classified commands in a two-entry queue. Depends on hsi_pkg.
`timescale 1ns / 1ps

module hsi_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  hsi_pkg::req_t       req,
	input  logic                cmd_pop,
	output hsi_pkg::cmd_beat_t  cmd_out
);

	hsi_pkg::cmd_t ent_q [2];
	logic [1:0]    cnt_q;
	logic          wr_q;
	logic          rd_q;
	logic          do_push;
	logic          do_pop;
	hsi_pkg::cmd_t cls;

	assign full    = (cnt_q == 2'd2);
	assign do_push = push && !full;
	assign do_pop  = cmd_pop && (cnt_q != 2'd0);

	always_comb begin
		cls.op  = req.op;
		cls.key = hsi_pkg::mask_key(req.key);
		cls.idx = hsi_pkg::bucket_of(cls.key);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= cls;
		end
	end

	assign cmd_out.valid = (cnt_q != 2'd0);
	assign cmd_out.cmd   = ent_q[rd_q];

endmodule

>>> hw/rtl/hsi_res_queue.sv
// Two-entry result queue that parts the back end from the result port.
// Depends on hsi_pkg.
`timescale 1ns / 1ps

module hsi_res_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  hsi_pkg::res_t wr_data,
	output logic          wr_full,
	output logic          empty,
	input  logic          pop,
	output hsi_pkg::res_t res
);

	hsi_pkg::res_t ent_q [2];
	logic [1:0]    cnt_q;
	logic          wr_q;
	logic          rd_q;
	logic          do_push;
	logic          do_pop;

	assign wr_full = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = wr_en && !wr_full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= wr_data;
		end
	end

	assign res = ent_q[rd_q];

endmodule

>>> hw/rtl/hsi_back.sv
// Back end: reads one bucket row, compares all ways, inserts into the
// lowest free way and keeps the entry count; clears valid rows after reset.
// Depends on hsi_pkg.
`timescale 1ns / 1ps

module hsi_back (
	input  logic               clk,
	input  logic               arst_n,
	input  hsi_pkg::cmd_beat_t cmd_in,
	output logic               cmd_pop,
	input  logic               res_full,
	output logic               res_push,
	output hsi_pkg::res_t      res_data
);

	typedef enum logic [1:0] {
		S_CLR,
		S_IDLE,
		S_CMP
	} state_t;

	localparam int ROW_BITS = hsi_pkg::WAYS * hsi_pkg::KEY_BITS;

	state_t                            state_q;
	logic [hsi_pkg::COUNT_BITS-1:0]    count_q;
	logic [hsi_pkg::IDX_BITS-1:0]      clr_idx_q;
	logic [hsi_pkg::WAYS-1:0]          valid_mem [hsi_pkg::BUCKETS];
	logic [ROW_BITS-1:0]               key_mem [hsi_pkg::BUCKETS];

	hsi_pkg::op_t                      op_s1;
	logic [hsi_pkg::IDX_BITS-1:0]      idx_s1;
	logic [hsi_pkg::KEY_BITS-1:0]      key_s1;
	logic [ROW_BITS-1:0]               rd_key_s1;
	logic [hsi_pkg::WAYS-1:0]          rd_valid_s1;

	logic                              issue;
	logic                              found;
	logic                              have_free;
	logic [hsi_pkg::WAY_BITS-1:0]      free_way;
	logic [hsi_pkg::WAYS-1:0]          set_way;
	logic                              do_ins;
	logic [hsi_pkg::COUNT_BITS-1:0]    count_nxt;

	assign issue   = (state_q == S_IDLE) && cmd_in.valid && !res_full;
	assign cmd_pop = issue;

	always_comb begin
		found     = 1'b0;
		have_free = 1'b0;
		free_way  = '0;
		for (int w = hsi_pkg::WAYS - 1; w >= 0; w--) begin
			if (rd_valid_s1[w]) begin
				if (rd_key_s1[w*hsi_pkg::KEY_BITS +: hsi_pkg::KEY_BITS] == key_s1) begin
					found = 1'b1;
				end
			end else begin
				have_free = 1'b1;
				free_way  = hsi_pkg::WAY_BITS'(w);
			end
		end
	end

	assign set_way   = hsi_pkg::WAYS'(1) << free_way;
	assign do_ins    = (state_q == S_CMP) && (op_s1 == hsi_pkg::OP_ADD) && !found && have_free;
	assign count_nxt = (count_q == hsi_pkg::COUNT_BITS'(hsi_pkg::COUNT_MAX)) ?
		count_q : count_q + 1'b1;

	assign res_push             = (state_q == S_CMP);
	assign res_data.hit         = (op_s1 == hsi_pkg::OP_QUERY) ? found : do_ins;
	assign res_data.bucket_full = (op_s1 == hsi_pkg::OP_ADD) && !found && !have_free;
	assign res_data.count       = do_ins ? count_nxt : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			count_q   <= '0;
			clr_idx_q <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == hsi_pkg::IDX_BITS'(hsi_pkg::BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (issue) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_IDLE;
					if (do_ins) begin
						count_q <= count_nxt;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			op_s1       <= cmd_in.cmd.op;
			idx_s1      <= cmd_in.cmd.idx;
			key_s1      <= cmd_in.cmd.key;
			rd_key_s1   <= key_mem[cmd_in.cmd.idx];
			rd_valid_s1 <= valid_mem[cmd_in.cmd.idx];
		end
		if (state_q == S_CLR) begin
			valid_mem[clr_idx_q] <= '0;
		end
		if (do_ins) begin
			valid_mem[idx_s1] <= rd_valid_s1 | set_way;
			key_mem[idx_s1][free_way*hsi_pkg::KEY_BITS +: hsi_pkg::KEY_BITS] <= key_s1;
		end
	end

endmodule

>>> hw/rtl/hash_set_insert_lookup.sv
// Bucketed hash set with add and membership query; one result per item.
// Each request beat is queued in the front end, then its bucket row is read
// and the compare and write back follow in the back end, which takes no new
// item until the last one is through them or while the result queue is full.
// Reset: count clears at once; valid rows clear in a pass over all 256 buckets after reset.
// Depends on hsi_pkg, hsi_front, hsi_back, hsi_res_queue.
`timescale 1ns / 1ps

module hash_set_insert_lookup (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  hsi_pkg::req_t req,
	output logic          empty,
	input  logic          pop,
	output hsi_pkg::res_t res
);

	hsi_pkg::cmd_beat_t cmd_beat;
	logic               cmd_pop;
	logic               res_full;
	logic               res_push;
	hsi_pkg::res_t      res_data;

	hsi_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.req     (req),
		.cmd_pop (cmd_pop),
		.cmd_out (cmd_beat)
	);

	hsi_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_in   (cmd_beat),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res_data (res_data)
	);

	hsi_res_queue u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_data),
		.wr_full (res_full),
		.empty   (empty),
		.pop     (pop),
		.res     (res)
	);

endmodule
